### rtl/alhy_pkg.sv
// Shared types, codes and constants for the averaged level alarm block.
`default_nettype none

package alhy_pkg;

	// Fixed field widths
	localparam int LEVEL_BITS = 12;
	localparam int COUNT_BITS = 8;

	// Default sample width handed to the top level
	localparam int SAMPLE_BITS_DEF = 12;

	// Register reset values
	localparam logic [LEVEL_BITS-1:0] THRESHOLD_RST  = 12'd1500;
	localparam logic [LEVEL_BITS-1:0] MARGIN_RST     = 12'd500;
	localparam logic [LEVEL_BITS-1:0] HYSTERESIS_RST = 12'd200;
	localparam logic [COUNT_BITS-1:0] COUNT_RST      = 8'd75;

	// Register indexes
	localparam int CFG_IDX_BITS = 2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_MARGIN     = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_HYSTERESIS = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_COUNT      = 2'd3;

	// Level class codes
	typedef enum logic [1:0] {
		CLASS_OK     = 2'd0,
		CLASS_MEDIUM = 2'd1,
		CLASS_ALARM  = 2'd2
	} air_class_t;

	// Latch event codes
	typedef enum logic [1:0] {
		EVT_NONE  = 2'd0,
		EVT_SET   = 2'd1,
		EVT_CLEAR = 2'd2
	} latch_evt_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIN
	} state_t;

	// Live configuration
	typedef struct packed {
		logic [LEVEL_BITS-1:0] threshold;
		logic [LEVEL_BITS-1:0] margin;
		logic [LEVEL_BITS-1:0] hysteresis;
		logic [COUNT_BITS-1:0] count;
	} cfg_t;

	// Controller to datapath commands
	typedef struct packed {
		logic accept;
		logic div_step;
		logic finish;
	} ctrl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic last_sample;
	} dp_status_t;

endpackage

`default_nettype wire

### rtl/averaged_level_alarm_hysteresis.sv
// Averaged level alarm with hysteresis latch: top level.
//
// Input channel in_valid/in_ready carries one sample per request. Samples are
// summed until cfg.count of them (a count of 0 acts as 1) form a batch; a
// sample that does not close a batch leaves in_ready high. The closing sample
// starts a restoring divider that yields one quotient bit a cycle; when the
// mean is ready the result register loads in ST_FIN as soon as the output
// slot is free, and out_valid rises in the cycle after the load.
// Output channel out_valid/out_ready carries one result request per batch. The
// result register frees the input side: samples keep being accepted while a
// result waits, and only a second finished batch waits for the receiver.
// in_ready is low while dividing and while a finished mean waits for the slot.
// Configuration is written through cfg_wr_en/cfg_index/cfg_data, one cycle a
// write, and should change only while no batch is being divided.
// Reset (arst_n low) restores the register defaults, empties the accumulator,
// clears the alarm latch and drops out_valid.
`default_nettype none

module averaged_level_alarm_hysteresis #(
	parameter int SAMPLE_BITS = alhy_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [alhy_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [alhy_pkg::LEVEL_BITS-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [SAMPLE_BITS-1:0]              sample,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [alhy_pkg::LEVEL_BITS-1:0]     average,
	output logic [alhy_pkg::LEVEL_BITS-1:0]     reported_level,
	output logic [1:0]                          air_class,
	output logic                                alarm_latched,
	output logic [1:0]                          latch_event
);
	import alhy_pkg::*;

	cfg_t       cfg;
	ctrl_cmd_t  cmd;
	dp_status_t status;

	alhy_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	alhy_ctrl #(.SAMPLE_BITS(SAMPLE_BITS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	alhy_dp #(.SAMPLE_BITS(SAMPLE_BITS)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.cmd            (cmd),
		.status         (status),
		.sample         (sample),
		.average        (average),
		.reported_level (reported_level),
		.air_class      (air_class),
		.alarm_latched  (alarm_latched),
		.latch_event    (latch_event)
	);

	// A loaded result is always offered on the next cycle
	a_finish_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid)
		else $error("result loaded but not offered");

	// A set event or an alarm class leaves the latch set
	a_set_latched: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (latch_event == EVT_SET || air_class == CLASS_ALARM) |-> alarm_latched)
		else $error("alarm without latch");

	// A clear event leaves the latch clear
	a_clear_unlatched: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && latch_event == EVT_CLEAR |-> !alarm_latched)
		else $error("clear event with latch still set");

	// Without the latch the reported level is the plain mean
	a_report_plain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !alarm_latched |-> reported_level == average)
		else $error("level clamped while latch clear");

endmodule

`default_nettype wire

### rtl/alhy_cfg_regs.sv
// Configuration register file written through the plain write port.
`default_nettype none

module alhy_cfg_regs (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_wr_en,
	input  logic [alhy_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [alhy_pkg::LEVEL_BITS-1:0]        cfg_data,
	output alhy_pkg::cfg_t                         cfg
);
	import alhy_pkg::*;

	cfg_t cfg_q;

	// Register writes, decoded by index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold  <= THRESHOLD_RST;
			cfg_q.margin     <= MARGIN_RST;
			cfg_q.hysteresis <= HYSTERESIS_RST;
			cfg_q.count      <= COUNT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_THRESHOLD:  cfg_q.threshold  <= cfg_data;
				CFG_MARGIN:     cfg_q.margin     <= cfg_data;
				CFG_HYSTERESIS: cfg_q.hysteresis <= cfg_data;
				CFG_COUNT:      cfg_q.count      <= cfg_data[COUNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

### rtl/alhy_ctrl.sv
// Controller: sequences accumulate, divide and result load, owns the result valid flag.
`default_nettype none

module alhy_ctrl #(
	parameter int SAMPLE_BITS = alhy_pkg::SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	input  alhy_pkg::dp_status_t   status,
	output alhy_pkg::ctrl_cmd_t    cmd
);
	import alhy_pkg::*;

	// One divider iteration per quotient bit
	localparam int DIV_STEPS = SAMPLE_BITS + COUNT_BITS;
	localparam int STEP_BITS = $clog2(DIV_STEPS);
	localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(DIV_STEPS - 1);

	state_t                state_q, state_d;
	logic [STEP_BITS-1:0]  step_q;
	logic                  out_valid_q;
	logic                  slot_free;

	assign slot_free = !out_valid_q || out_ready;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && status.last_sample)
					state_d = ST_DIV;
			end
			ST_DIV: begin
				if (step_q == STEP_LAST)
					state_d = ST_FIN;
			end
			ST_FIN: begin
				if (slot_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_DIV:  cmd.div_step = 1'b1;
			ST_FIN:  cmd.finish   = slot_free;
			default: ;
		endcase
	end

	// State, iteration count and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.accept)
				step_q <= '0;
			else if (cmd.div_step)
				step_q <= step_q + 1'b1;
			if (cmd.finish)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

### rtl/alhy_dp.sv
// Datapath: batch accumulator, restoring divider, classifier, alarm latch, result register.
`default_nettype none

module alhy_dp #(
	parameter int SAMPLE_BITS = alhy_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  alhy_pkg::cfg_t                      cfg,
	input  alhy_pkg::ctrl_cmd_t                 cmd,
	output alhy_pkg::dp_status_t                status,
	input  logic [SAMPLE_BITS-1:0]              sample,
	output logic [alhy_pkg::LEVEL_BITS-1:0]     average,
	output logic [alhy_pkg::LEVEL_BITS-1:0]     reported_level,
	output logic [1:0]                          air_class,
	output logic                                alarm_latched,
	output logic [1:0]                          latch_event
);
	import alhy_pkg::*;

	localparam int SUM_BITS = SAMPLE_BITS + COUNT_BITS;
	localparam int DIV_BITS = COUNT_BITS + 1;   // room for a divisor of 256
	localparam int CMP_BITS = (SAMPLE_BITS > LEVEL_BITS) ? SAMPLE_BITS : LEVEL_BITS;

	logic [SUM_BITS-1:0]   sum_q, sum_next;
	logic [COUNT_BITS-1:0] taken_q, cnt_next, target;
	logic                  latch_q, latch_next;

	logic [SUM_BITS-1:0]   quo_q;
	logic [DIV_BITS-1:0]   rem_q, dvsr_q;
	logic [DIV_BITS:0]     rem_sh, rem_diff;
	logic                  take_sub;

	logic [CMP_BITS-1:0]   avg_ext, thr_ext, medium_ext, release_ext, reported_ext;
	logic [LEVEL_BITS-1:0] medium_level, release_level;
	logic                  alarm_cond, below;
	air_class_t            class_d, class_q;
	latch_evt_t            evt_d, evt_q;
	logic [LEVEL_BITS-1:0] avg_q, reported_q;
	logic                  latched_q;

	// Batch bookkeeping
	always_comb begin
		sum_next           = sum_q + SUM_BITS'(sample);
		cnt_next           = taken_q + 1'b1;
		target             = (cfg.count == '0) ? COUNT_BITS'(1) : cfg.count;
		status.last_sample = (cnt_next == '0) || (cnt_next >= target);
	end

	// One restoring division step
	always_comb begin
		rem_sh   = {rem_q, quo_q[SUM_BITS-1]};
		rem_diff = rem_sh - {1'b0, dvsr_q};
		take_sub = rem_sh >= {1'b0, dvsr_q};
	end

	// Classification and hysteresis latch on the finished mean
	always_comb begin
		medium_level  = (cfg.threshold >= cfg.margin) ? cfg.threshold - cfg.margin : '0;
		release_level = (cfg.threshold >= cfg.hysteresis) ?
		                cfg.threshold - cfg.hysteresis : '0;
		avg_ext     = CMP_BITS'(quo_q[SAMPLE_BITS-1:0]);
		thr_ext     = CMP_BITS'(cfg.threshold);
		medium_ext  = CMP_BITS'(medium_level);
		release_ext = CMP_BITS'(release_level);
		alarm_cond  = avg_ext >= thr_ext;
		below       = avg_ext < release_ext;

		if (alarm_cond)
			class_d = CLASS_ALARM;
		else if (avg_ext >= medium_ext)
			class_d = CLASS_MEDIUM;
		else
			class_d = CLASS_OK;

		latch_next = latch_q;
		evt_d      = EVT_NONE;
		if (alarm_cond && !latch_q) begin
			latch_next = 1'b1;
			evt_d      = EVT_SET;
		end else if (below && latch_q) begin
			latch_next = 1'b0;
			evt_d      = EVT_CLEAR;
		end

		reported_ext = (latch_next && !alarm_cond) ? thr_ext : avg_ext;
	end

	// Accumulator, sample counter and latch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			taken_q <= '0;
			latch_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				if (status.last_sample) begin
					sum_q   <= '0;
					taken_q <= '0;
				end else begin
					sum_q   <= sum_next;
					taken_q <= cnt_next;
				end
			end
			if (cmd.finish)
				latch_q <= latch_next;
		end
	end

	// Divider registers and result register
	always_ff @(posedge clk) begin
		if (cmd.accept && status.last_sample) begin
			quo_q  <= sum_next;
			rem_q  <= '0;
			dvsr_q <= {cnt_next == '0, cnt_next};
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[SUM_BITS-2:0], take_sub};
			rem_q <= take_sub ? rem_diff[DIV_BITS-1:0] : rem_sh[DIV_BITS-1:0];
		end
		if (cmd.finish) begin
			avg_q      <= avg_ext[LEVEL_BITS-1:0];
			reported_q <= reported_ext[LEVEL_BITS-1:0];
			class_q    <= class_d;
			latched_q  <= latch_next;
			evt_q      <= evt_d;
		end
	end

	assign average        = avg_q;
	assign reported_level = reported_q;
	assign air_class      = class_q;
	assign alarm_latched  = latched_q;
	assign latch_event    = evt_q;

endmodule

`default_nettype wire

### verif/testbench.sv
// Testbench for the averaged level alarm block, with its own result predictor.
`timescale 1ns / 100ps

module testbench;
	import alhy_pkg::*;

	localparam int SAMPLE_W       = SAMPLE_BITS_DEF;
	localparam int SETTLE_CYCLES  = SAMPLE_BITS_DEF + 8 + 20;
	localparam int TIMEOUT_CYCLES = 500_000;
	localparam int HOLD_CYCLES    = 300;

	// One batch result as the block should report it
	typedef struct {
		logic [LEVEL_BITS-1:0] average;
		logic [LEVEL_BITS-1:0] reported;
		air_class_t            cls;
		logic                  latched;
		latch_evt_t            evt;
	} level_result_t;

	// Batch averager and alarm latch, plus the queue of results still owed
	class alarm_scoreboard;
		logic [LEVEL_BITS-1:0]   thr, margin, hyst;
		logic [COUNT_BITS-1:0]   count;
		logic [SAMPLE_W+7:0]     sum;
		logic [COUNT_BITS-1:0]   taken;
		logic                    latch;
		level_result_t           due_results[$];
		int                      errors;

		function new();
			thr    = THRESHOLD_RST;
			margin = MARGIN_RST;
			hyst   = HYSTERESIS_RST;
			count  = COUNT_RST;
			sum    = '0;
			taken  = '0;
			latch  = 1'b0;
			errors = 0;
		endfunction

		function logic [LEVEL_BITS-1:0] sat_sub(logic [LEVEL_BITS-1:0] a,
				logic [LEVEL_BITS-1:0] b);
			return (a >= b) ? a - b : '0;
		endfunction

		function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [LEVEL_BITS-1:0] data);
			case (idx)
			CFG_THRESHOLD:  thr = data;
			CFG_MARGIN:     margin = data;
			CFG_HYSTERESIS: hyst = data;
			CFG_COUNT:      count = data[COUNT_BITS-1:0];
			default: ;
			endcase
		endfunction

		// Samples still needed to close the current batch
		function int batch_left();
			int tgt;
			tgt = (count == 0) ? 1 : int'(count);
			return (tgt > int'(taken)) ? tgt - int'(taken) : 1;
		endfunction

		function void note_sample(logic [SAMPLE_W-1:0] s);
			logic [8:0]          n;
			logic [SAMPLE_W+7:0] quot;
			level_result_t       r;
			sum = sum + (SAMPLE_W+8)'(s);
			n = 9'(taken) + 9'd1;
			// a count of zero closes every sample; a lowered count closes at once
			if (n < ((count == 0) ? 9'd1 : 9'(count))) begin
				taken = n[COUNT_BITS-1:0];
				return;
			end
			quot = sum / (SAMPLE_W+8)'(n);
			r.average = quot[LEVEL_BITS-1:0];
			sum = '0;
			taken = '0;
			if (r.average >= thr)
				r.cls = CLASS_ALARM;
			else if (r.average >= sat_sub(thr, margin))
				r.cls = CLASS_MEDIUM;
			else
				r.cls = CLASS_OK;
			r.evt = EVT_NONE;
			if (r.average >= thr && !latch) begin
				latch = 1'b1;
				r.evt = EVT_SET;
			end else if (r.average < sat_sub(thr, hyst) && latch) begin
				latch = 1'b0;
				r.evt = EVT_CLEAR;
			end
			r.latched = latch;
			r.reported = (latch && r.average < thr) ? thr : r.average;
			due_results.push_back(r);
		endfunction

		function void check_result(logic [LEVEL_BITS-1:0] avg, logic [LEVEL_BITS-1:0] rep,
				logic [1:0] cls, logic lat, logic [1:0] evt);
			level_result_t         e;
			logic [LEVEL_BITS-1:0] want [5];
			logic [LEVEL_BITS-1:0] got [5];
			string                 names [5];
			if (due_results.size() == 0) begin
				$error("result with none expected: average %0d", avg);
				errors++;
				return;
			end
			e = due_results.pop_front();
			want  = '{e.average, e.reported, LEVEL_BITS'(e.cls), LEVEL_BITS'(e.latched),
				LEVEL_BITS'(e.evt)};
			got   = '{avg, rep, LEVEL_BITS'(cls), LEVEL_BITS'(lat), LEVEL_BITS'(evt)};
			names = '{"average", "reported_level", "air_class", "alarm_latched",
				"latch_event"};
			for (int i = 0; i < 5; i++)
				if (got[i] !== want[i]) begin
					$error("%s: expected %0d, got %0d", names[i], want[i], got[i]);
					errors++;
				end
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n = 1'b0;
	logic                          cfg_wr_en = 1'b0;
	logic [CFG_IDX_BITS-1:0]       cfg_index = CFG_THRESHOLD;
	logic [LEVEL_BITS-1:0]         cfg_data = '0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic [SAMPLE_W-1:0]           sample = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [LEVEL_BITS-1:0]         average;
	logic [LEVEL_BITS-1:0]         reported_level;
	logic [1:0]                    air_class;
	logic                          alarm_latched;
	logic [1:0]                    latch_event;

	alarm_scoreboard sb;
	int snd_idle_pct = 0;
	int rcv_stall_pct = 0;
	int hold_left = 0;

	averaged_level_alarm_hysteresis #(.SAMPLE_BITS(SAMPLE_W)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample(sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.average(average),
		.reported_level(reported_level),
		.air_class(air_class),
		.alarm_latched(alarm_latched),
		.latch_event(latch_event)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog
	initial begin
		#(TIMEOUT_CYCLES * 12);
		$display("Test completed with failures");
		$finish;
	end

	// Result side: random stalls, long hold-off on request, check on each request
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(average, reported_level, air_class, alarm_latched, latch_event);
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rcv_stall_pct);
		end
	end

	// Offer one sample, with random idle cycles first, and wait for the request
	task automatic send_sample(input logic [SAMPLE_W-1:0] v);
		while ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= v;
		do @(posedge clk); while (!in_ready);
		sb.note_sample(v);
	endtask

	task automatic send_each(input int vals[$]);
		foreach (vals[i])
			send_sample(SAMPLE_W'(vals[i]));
	endtask

	// Drain outstanding results, then let any batch still in the divider finish
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.due_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_settings(input logic [LEVEL_BITS-1:0] thr,
			input logic [LEVEL_BITS-1:0] mar, input logic [LEVEL_BITS-1:0] hys,
			input logic [LEVEL_BITS-1:0] cnt_raw);
		logic [LEVEL_BITS-1:0]   vals [4];
		logic [CFG_IDX_BITS-1:0] idxs [4];
		settle();
		vals = '{thr, mar, hys, cnt_raw};
		idxs = '{CFG_THRESHOLD, CFG_MARGIN, CFG_HYSTERESIS, CFG_COUNT};
		foreach (vals[i]) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= idxs[i];
			cfg_data <= vals[i];
			@(posedge clk);
			sb.write_reg(idxs[i], vals[i]);
		end
		cfg_wr_en <= 1'b0;
	endtask

	// Batch level aimed at the class and latch boundaries
	function automatic logic [LEVEL_BITS-1:0] pick_level();
		logic [LEVEL_BITS-1:0] med, rel;
		med = sb.sat_sub(sb.thr, sb.margin);
		rel = sb.sat_sub(sb.thr, sb.hyst);
		case ($urandom_range(9))
		0: return sb.thr;
		1: return sb.sat_sub(sb.thr, 12'd1);
		2: return med;
		3: return sb.sat_sub(med, 12'd1);
		4: return rel;
		5: return sb.sat_sub(rel, 12'd1);
		6: return '0;
		7: return '1;
		default: return LEVEL_BITS'($urandom_range(4095));
		endcase
	endfunction

	// Whole batches around a chosen level, some batches pure noise
	task automatic send_batches(input int n_items, input int jit);
		int                    sent;
		int                    left;
		int                    v;
		bit                    noisy;
		logic [LEVEL_BITS-1:0] lvl;
		sent = 0;
		while (sent < n_items) begin
			left = sb.batch_left();
			lvl = pick_level();
			noisy = ($urandom_range(99) < 15);
			for (int k = 0; k < left && sent < n_items; k++) begin
				if (noisy)
					v = int'($urandom_range(4095));
				else
					v = int'(lvl) + int'($urandom_range(2 * jit)) - jit;
				if (v < 0)
					v = 0;
				if (v > 4095)
					v = 4095;
				send_sample(SAMPLE_W'(v));
				sent++;
			end
		end
	endtask

	initial begin
		logic [LEVEL_BITS-1:0] thr, mar, hys;
		int                    cnt;
		int                    full_batch[$];
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: two long batches
		send_batches(150, 2);

		// One-sample batches across every class and latch edge
		write_settings(12'd1500, 12'd500, 12'd200, 12'd1);
		send_each({0, 4095, 1499, 1300, 1299, 1000, 999, 1500});

		// Threshold zero, zero count via masked upper bits, saturating differences
		write_settings(12'd0, 12'd4095, 12'd4095, 12'h100);
		send_each({0, 4095});
		write_settings(12'd100, 12'd4095, 12'd4095, 12'hF03);
		send_each({50, 0, 0});

		// Count lowered part way through a batch
		write_settings(12'd4095, 12'd1, 12'd4094, 12'd20);
		send_each({4095, 4095, 4095, 4095, 4095, 4095, 4095});
		write_settings(12'd4095, 12'd1, 12'd4094, 12'd3);
		send_each({4095, 1, 0, 0});

		// Largest batch at full scale
		write_settings(12'd4000, 12'd100, 12'd50, 12'd255);
		for (int i = 0; i < 255; i++)
			full_batch.push_back(4095);
		send_each(full_batch);

		// Corner then random settings, cycling through the idling modes
		for (int p = 0; p < 12; p++) begin
			case (p)
			0: begin thr = 12'd4095; mar = 12'd0;    hys = 12'd0;    cnt = 1; end
			1: begin thr = 12'd0;    mar = 12'd4095; hys = 12'd4095; cnt = 2; end
			2: begin thr = 12'd1;    mar = 12'd1;    hys = 12'd1;    cnt = 0; end
			default: begin
				thr = LEVEL_BITS'($urandom_range(4095));
				mar = ($urandom_range(3) == 0) ? LEVEL_BITS'($urandom_range(4095))
					: LEVEL_BITS'($urandom_range(600));
				hys = ($urandom_range(3) == 0) ? LEVEL_BITS'($urandom_range(4095))
					: LEVEL_BITS'($urandom_range(600));
				cnt = ($urandom_range(5) == 0) ? int'($urandom_range(40, 9))
					: int'($urandom_range(8, 1));
			end
			endcase
			write_settings(thr, mar, hys,
				{4'($urandom_range(15)), COUNT_BITS'(cnt)});
			case (p % 4)
			0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
			1: begin snd_idle_pct = 85; rcv_stall_pct = 0;  end
			2: begin snd_idle_pct = 0;  rcv_stall_pct = 85; end
			default: begin snd_idle_pct = 35; rcv_stall_pct = 35; end
			endcase
			// receiver holds off while samples keep coming, filling the block
			if (p == 4)
				hold_left = HOLD_CYCLES;
			send_batches(60, int'($urandom_range(2)));
		end

		settle();
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
